// ----- hdl/led_step_sequence_player_macros.svh -----
// Assertion macros shared by the RTL of the LED step sequence player.
// Define NO_ASSERTIONS to compile them away.
`ifndef LED_STEP_SEQUENCE_PLAYER_MACROS_SVH
`define LED_STEP_SEQUENCE_PLAYER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define LSSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSSP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LSSP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/lssp_pkg.sv -----
package lssp_pkg;

    localparam int FUNC_W     = 2;
    localparam int TIME_W     = 32;
    localparam int SLOT_W     = 4;
    localparam int COLOR_W    = 24;
    localparam int DUR_W      = 16;
    localparam int COUNT_W    = 5;
    localparam int STEP_OUT_W = 4;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int DIV_STEPS  = CH_W;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

    // One table entry as it is stored in the step memory.
    typedef struct packed {
        logic               fade;
        logic [DUR_W-1:0]   duration;
        logic [COLOR_W-1:0] color;
    } t_step;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_CALC,
        S_BLEND,
        S_DONE
    } t_state;

    // Request to the fade blend unit.
    typedef struct packed {
        logic               start;
        logic [COLOR_W-1:0] origin;
        logic [COLOR_W-1:0] target;
        logic [DUR_W-1:0]   e;
        logic [DUR_W-1:0]   d;
    } t_blend_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_blend_sts;

endpackage

// ----- hdl/lssp_item_if.sv -----
interface lssp_item_if;
    import lssp_pkg::*;

    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [TIME_W-1:0]  now_ms;
    logic [SLOT_W-1:0]  step_slot;
    logic [COLOR_W-1:0] step_color;
    logic [DUR_W-1:0]   step_duration;
    logic               step_fade;

    modport source (
        output valid, func, now_ms, step_slot, step_color, step_duration, step_fade,
        input  ready
    );

    modport sink (
        input  valid, func, now_ms, step_slot, step_color, step_duration, step_fade,
        output ready
    );
endinterface

// ----- hdl/lssp_result_if.sv -----
interface lssp_result_if;
    import lssp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COLOR_W-1:0]    color_out;
    logic [STEP_OUT_W-1:0] step_now;

    modport source (
        output valid, color_out, step_now,
        input  ready
    );

    modport sink (
        input  valid, color_out, step_now,
        output ready
    );
endinterface

// ----- hdl/led_step_sequence_player.sv -----
// Channel     Direction  Payload
// ----------  ---------  ------------------------------------------------------
// i_item      in         func, now_ms, step_slot, step_color, step_duration, step_fade
// o_result    out        color_out, step_now
// i_cfg_*     in         loop length register (write only, no handshake)
//
// Every accepted transaction yields exactly one result transaction. Write,
// restart, unused codes and ticks with a zero count go straight to the done
// state; other ticks read the step entry (twice when they advance), and a
// fade waits for the eight-step restoring division in the blend unit.
// A new item is accepted the cycle after a result is loaded, even while it waits in
// the output register; a second finished result holds the input off until then.
// Reset (synchronous, active low) clears the sequence state and sets the loop
// length to 1; the step table is undefined until written.
`include "led_step_sequence_player_macros.svh"

module led_step_sequence_player #(
    parameter int MAX_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    lssp_item_if.sink                    i_item,
    lssp_result_if.source                o_result,
    input  logic                         i_cfg_we,
    input  logic [lssp_pkg::COUNT_W-1:0] i_cfg_data
);
    import lssp_pkg::*;

    localparam int             IDX_W     = $clog2(MAX_STEPS);
    localparam logic [8:0]     STEPS_LIM = 9'(MAX_STEPS);

    // Control state.
    t_state               r_state,     n_state;
    logic [IDX_W-1:0]     r_step_idx,  n_step_idx;
    logic [TIME_W-1:0]    r_start,     n_start;
    logic [COLOR_W-1:0]   r_origin,    n_origin;
    logic [COLOR_W-1:0]   r_shown,     n_shown;
    logic                 r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]   r_count;

    // Payload registers.
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_elapsed;
    t_step                 r_entry;
    logic [COLOR_W-1:0]    r_out_color;
    logic [STEP_OUT_W-1:0] r_out_step;

    logic                 item_acc;
    logic                 out_load;
    logic                 slot_ok;
    logic [8:0]           slot_ext;
    logic [8:0]           count_lim;
    logic [8:0]           idx_inc;
    logic [8:0]           idx_ext;
    logic [IDX_W-1:0]     next_idx;
    logic [TIME_W-1:0]    elapsed_now;
    logic                 do_adv;
    logic [DUR_W-1:0]     e_clamp;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    t_step                ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    t_step                ram_rdata;

    t_blend_req           blend_req;
    t_blend_sts           blend_sts;
    logic [COLOR_W-1:0]   blend_color;

    lssp_ram #(
        .WIDTH ($bits(t_step)),
        .DEPTH (MAX_STEPS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lssp_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (blend_req),
        .o_sts   (blend_sts),
        .o_color (blend_color)
    );

    assign item_acc = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // Table writes to slots beyond the table depth are dropped.
    assign slot_ext  = 9'(i_item.step_slot);
    assign slot_ok   = (slot_ext < STEPS_LIM);

    // A step count above the table depth behaves as the full table.
    assign count_lim = (9'(r_count) > STEPS_LIM) ? STEPS_LIM : 9'(r_count);
    assign idx_ext   = 9'(r_step_idx);
    assign idx_inc   = idx_ext + 9'd1;
    assign next_idx  = (idx_inc >= count_lim) ? '0 : idx_inc[IDX_W-1:0];

    // Wrapping time since the current step started; the step is over once this
    // reaches its duration.
    assign elapsed_now = r_now - r_start;
    assign do_adv      = (elapsed_now >= TIME_W'(ram_rdata.duration));

    assign e_clamp = (r_elapsed > TIME_W'(r_entry.duration)) ? r_entry.duration
                                                              : r_elapsed[DUR_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_step_idx  = r_step_idx;
        n_start     = r_start;
        n_origin    = r_origin;
        n_shown     = r_shown;
        n_out_valid = r_out_valid && !o_result.ready;
        out_load    = 1'b0;

        ram_we             = 1'b0;
        ram_waddr          = slot_ext[IDX_W-1:0];
        ram_wdata.fade     = i_item.step_fade;
        ram_wdata.duration = i_item.step_duration;
        ram_wdata.color    = i_item.step_color;
        ram_raddr          = r_step_idx;

        blend_req.start  = 1'b0;
        blend_req.origin = r_origin;
        blend_req.target = r_entry.color;
        blend_req.e      = e_clamp;
        blend_req.d      = r_entry.duration;

        unique case (r_state)
            S_IDLE: begin
                // The memory reads the current step continuously, so a tick has
                // its entry in the cycle after acceptance.
                if (item_acc) begin
                    unique case (i_item.func)
                        FUNC_TICK: begin
                            n_state = (r_count == '0) ? S_DONE : S_RD1;
                        end
                        FUNC_WRITE: begin
                            ram_we  = slot_ok;
                            n_state = S_DONE;
                        end
                        FUNC_RESTART: begin
                            n_step_idx = '0;
                            n_start    = i_item.now_ms;
                            n_origin   = '0;
                            n_state    = S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_RD1: begin
                if (do_adv) begin
                    // Move on one step, restart the step clock and fade from
                    // whatever color is on display now.
                    n_step_idx = next_idx;
                    n_start    = r_now;
                    n_origin   = r_shown;
                    ram_raddr  = next_idx;
                    n_state    = S_RD2;
                end else begin
                    n_state = S_CALC;
                end
            end
            S_RD2: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                // Solid steps and zero-length fades show the target directly.
                if (!r_entry.fade || (r_entry.duration == '0)) begin
                    n_shown = r_entry.color;
                    n_state = S_DONE;
                end else begin
                    blend_req.start = 1'b1;
                    n_state         = S_BLEND;
                end
            end
            S_BLEND: begin
                if (blend_sts.done) begin
                    n_shown = blend_color;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step_idx  <= '0;
            r_start     <= '0;
            r_origin    <= '0;
            r_shown     <= '0;
            r_out_valid <= 1'b0;
            r_count     <= COUNT_W'(1);
        end else begin
            r_state     <= n_state;
            r_step_idx  <= n_step_idx;
            r_start     <= n_start;
            r_origin    <= n_origin;
            r_shown     <= n_shown;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_acc) begin
            r_now <= i_item.now_ms;
        end
        if (r_state == S_RD1) begin
            r_elapsed <= do_adv ? '0 : elapsed_now;
        end
        if (((r_state == S_RD1) && !do_adv) || (r_state == S_RD2)) begin
            r_entry <= ram_rdata;
        end
        if (out_load) begin
            r_out_color <= r_shown;
            r_out_step  <= idx_ext[STEP_OUT_W-1:0];
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.color_out = r_out_color;
    assign o_result.step_now  = r_out_step;

    `LSSP_ASSERT_IMP(a_wr_in_idle, i_clk, i_rst_n, ram_we, r_state == S_IDLE, "table write outside idle")
    `LSSP_ASSERT_IMP(a_blend_in_state, i_clk, i_rst_n, blend_sts.busy || blend_sts.done, r_state == S_BLEND, "blend unit active outside blend state")
    `LSSP_ASSERT_NXT(a_zero_count, i_clk, i_rst_n, item_acc && (i_item.func == FUNC_TICK) && (r_count == '0), $stable(r_step_idx) && $stable(r_shown), "tick with zero step count changed state")
    `LSSP_ASSERT_NXT(a_restart, i_clk, i_rst_n, item_acc && (i_item.func == FUNC_RESTART), (r_step_idx == '0) && (r_origin == '0), "restart did not rewind")
    `LSSP_ASSERT_NXT(a_done_issue, i_clk, i_rst_n, (r_state == S_DONE) && (!r_out_valid || o_result.ready), r_out_valid && (r_state == S_IDLE), "result not issued")

endmodule

// ----- hdl/lssp_ram.sv -----
module lssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/lssp_blend.sv -----
module lssp_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lssp_pkg::t_blend_req        i_req,
    output lssp_pkg::t_blend_sts        o_sts,
    output logic [lssp_pkg::COLOR_W-1:0] o_color
);
    import lssp_pkg::*;

    localparam int                CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0]  LAST_STEP = CNT_W'(DIV_STEPS - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [DUR_W-1:0]              r_d;
    logic [DUR_W-1:0]              d_minus_e;

    assign d_minus_e = i_req.d - i_req.e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_d <= i_req.d;
        end
    end

    // Each channel: num = origin*(d-e) + target*e, then a restoring division by d.
    // The numerator is below 256*d, so the quotient takes eight steps and the
    // quotient bits shift in where the low numerator bits shift out.
    for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
        logic [CH_W-1:0]    org;
        logic [CH_W-1:0]    tgt;
        logic [COLOR_W-1:0] prod_o;
        logic [COLOR_W-1:0] prod_t;
        logic [COLOR_W-1:0] num;
        logic [DUR_W-1:0]   r_rem;
        logic [CH_W-1:0]    r_low;
        logic [DUR_W:0]     trial;
        logic               q_bit;
        logic [DUR_W-1:0]   n_rem;

        assign org    = i_req.origin[c*CH_W +: CH_W];
        assign tgt    = i_req.target[c*CH_W +: CH_W];
        assign prod_o = COLOR_W'(org) * COLOR_W'(d_minus_e);
        assign prod_t = COLOR_W'(tgt) * COLOR_W'(i_req.e);
        assign num    = prod_o + prod_t;

        assign trial = {r_rem, r_low[CH_W-1]};
        assign q_bit = (trial >= {1'b0, r_d});
        assign n_rem = q_bit ? DUR_W'(trial - {1'b0, r_d}) : trial[DUR_W-1:0];

        always_ff @(posedge i_clk) begin
            if (i_req.start) begin
                r_rem <= num[COLOR_W-1:CH_W];
                r_low <= num[CH_W-1:0];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= {r_low[CH_W-2:0], q_bit};
            end
        end

        assign o_color[c*CH_W +: CH_W] = r_low;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

// ----- tb/led_step_sequence_player_tb.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the LED step sequence player.
//
// A directed table first loads every step slot, then walks through the
// corner cases of the player: the unused function code, a restart, fades,
// a zero-duration fade, the step count at its extremes and above the table
// size, a restart just before the time counter wraps, and a step count of
// zero. Then a series of random phases follows. Each phase programs a new
// step count while the block is idle and sends mostly ticks with a slowly
// advancing millisecond clock, mixed with table writes, restarts and
// unused codes. Every accepted item transaction is run through the bench's
// own player model and the predicted result is queued. The result side
// compares every result transaction with the oldest prediction.
module led_step_sequence_player_tb;
    import lssp_pkg::*;

    // The one code of the function field that the block does not use.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    localparam int LOOP_SLOTS      = 16;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 119;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;

    // One item transaction as the bench builds it.
    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [TIME_W-1:0]  now;
        logic [SLOT_W-1:0]  slot;
        logic [COLOR_W-1:0] color;
        logic [DUR_W-1:0]   dur;
        logic               fade;
    } t_led_item;

    // What the player shows after an item: the result transaction.
    typedef struct {
        logic [COLOR_W-1:0]    color;
        logic [STEP_OUT_W-1:0] step;
    } t_led_view;

    // One row of the directed table. A row may first reprogram the step
    // count, and may carry a hand-written expectation.
    typedef struct {
        bit                 set_len;
        logic [COUNT_W-1:0] len;
        t_led_item          item;
        bit                 typed;
        t_led_view          view;
    } t_led_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    lssp_item_if   item_bus ();
    lssp_result_if result_bus ();

    led_step_sequence_player #(
        .MAX_STEPS (LOOP_SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_bus),
        .o_result   (result_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    // Model of the player: the step table, the playing position, the time
    // the current step started, the fade origin, the shown colour and the
    // programmed step count.
    t_step              step_mem [LOOP_SLOTS];
    logic [SLOT_W-1:0]  play_idx;
    logic [TIME_W-1:0]  step_t0;
    logic [COLOR_W-1:0] origin_rgb;
    logic [COLOR_W-1:0] shown_rgb;
    logic [COUNT_W-1:0] loop_len;

    // Results predicted for accepted items, oldest first.
    t_led_view pending_views [$];

    int          errors;
    int unsigned cycle_cnt;
    // When set, neither side inserts idle cycles.
    bit          calm;
    // Set by the sender to make the receiver hold off for a long stretch.
    bit          hold_off_req;
    // The millisecond clock that random ticks follow.
    logic [TIME_W-1:0] wall_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The cycle counter ends a run that hangs.
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("led_step_sequence_player: mismatch");
        $finish;
    end

    // One channel of a linear fade: the origin weighted by the time left and
    // the target weighted by the time gone, divided by the step duration and
    // rounded down.
    function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] from,
                                                    logic [CH_W-1:0] to,
                                                    logic [DUR_W-1:0] e,
                                                    logic [DUR_W-1:0] d);
        int unsigned num;
        num = 32'(from) * (32'(d) - 32'(e)) + 32'(to) * 32'(e);
        return CH_W'(num / 32'(d));
    endfunction

    function automatic logic [COLOR_W-1:0] mix_rgb(logic [COLOR_W-1:0] from,
                                                   logic [COLOR_W-1:0] to,
                                                   logic [DUR_W-1:0] e,
                                                   logic [DUR_W-1:0] d);
        logic [COLOR_W-1:0] rgb;
        rgb = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            rgb[ch*CH_W +: CH_W] = mix_channel(from[ch*CH_W +: CH_W], to[ch*CH_W +: CH_W],
                                               e, d);
        end
        return rgb;
    endfunction

    // A tick: advance at most one step once the current one has run out,
    // then show the step's colour or its fade position.
    function automatic void play_tick(logic [TIME_W-1:0] now);
        int unsigned       len;
        int unsigned       nxt;
        logic [TIME_W-1:0] elapsed;
        t_step             cur;
        len = loop_len;
        // With a step count of zero the player stands still.
        if (len == 0) return;
        // Counts above the table size play the whole table.
        if (len > LOOP_SLOTS) len = LOOP_SLOTS;
        cur = step_mem[play_idx];
        elapsed = now - step_t0;
        if (elapsed >= TIME_W'(cur.duration)) begin
            // An index left beyond a lowered count wraps to zero here too.
            nxt = 32'(play_idx) + 1;
            if (nxt >= len) nxt = 0;
            play_idx   = SLOT_W'(nxt);
            step_t0    = now;
            origin_rgb = shown_rgb;
            elapsed    = '0;
            cur        = step_mem[play_idx];
        end
        if (!cur.fade || cur.duration == '0) begin
            shown_rgb = cur.color;
        end else if (elapsed > TIME_W'(cur.duration)) begin
            shown_rgb = cur.color;
        end else begin
            shown_rgb = mix_rgb(origin_rgb, cur.color, DUR_W'(elapsed), cur.duration);
        end
    endfunction

    // Applies one accepted item to the model and returns what it shows.
    function automatic t_led_view apply_item(t_led_item it);
        t_led_view got;
        case (it.func)
            FUNC_TICK: begin
                play_tick(it.now);
            end
            FUNC_WRITE: begin
                step_mem[it.slot].color    = it.color;
                step_mem[it.slot].duration = it.dur;
                step_mem[it.slot].fade     = it.fade;
            end
            FUNC_RESTART: begin
                // The shown colour stays; the next fade starts from black.
                play_idx   = '0;
                step_t0    = it.now;
                origin_rgb = '0;
            end
            default: begin
            end
        endcase
        got.color = shown_rgb;
        got.step  = play_idx;
        return got;
    endfunction

    // Idle stretch length: mostly none or short, now and then long.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_led_row make_row(bit set_len, logic [COUNT_W-1:0] len,
                                          logic [FUNC_W-1:0] func, logic [TIME_W-1:0] now,
                                          logic [SLOT_W-1:0] slot, logic [COLOR_W-1:0] color,
                                          logic [DUR_W-1:0] dur, logic fade, bit typed,
                                          logic [COLOR_W-1:0] exp_color,
                                          logic [STEP_OUT_W-1:0] exp_step);
        t_led_row row;
        row.set_len    = set_len;
        row.len        = len;
        row.item.func  = func;
        row.item.now   = now;
        row.item.slot  = slot;
        row.item.color = color;
        row.item.dur   = dur;
        row.item.fade  = fade;
        row.typed      = typed;
        row.view.color = exp_color;
        row.view.step  = exp_step;
        return row;
    endfunction

    // A random item. Most are ticks that follow the millisecond clock, so that
    // steps run out, advance and fade; the rest are table writes, restarts and
    // unused codes. Fields that the function ignores still carry random bits.
    function automatic t_led_item random_item();
        t_led_item it;
        int        r;
        int        q;
        it.now   = $urandom;
        it.slot  = SLOT_W'($urandom_range(0, 15));
        it.color = COLOR_W'($urandom);
        it.dur   = DUR_W'($urandom);
        it.fade  = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 70) begin
            it.func = FUNC_TICK;
            q = $urandom_range(0, 99);
            if (q < 80) wall_ms = wall_ms + $urandom_range(0, 5);
            else if (q < 97) wall_ms = wall_ms + $urandom_range(6, 60);
            else wall_ms = $urandom;
            it.now = wall_ms;
        end else if (r < 86) begin
            it.func = FUNC_WRITE;
            q = $urandom_range(0, 99);
            if (q < 10) it.dur = '0;
            else if (q < 70) it.dur = DUR_W'($urandom_range(1, 24));
            else if (q < 92) it.dur = DUR_W'($urandom_range(25, 300));
            else if (q < 97) it.dur = DUR_W'($urandom);
            else it.dur = '1;
        end else if (r < 96) begin
            it.func = FUNC_RESTART;
            if ($urandom_range(0, 9) != 0) it.now = wall_ms;
            else wall_ms = it.now;
        end else begin
            it.func = FUNC_UNUSED;
        end
        return it;
    endfunction

    // Offers one item transaction after an optional idle stretch and waits
    // until the block takes it. Valid stays high on return, so that a next
    // item without a gap follows directly.
    task automatic send_item(t_led_item it, int gap, bit typed, t_led_view typed_view);
        t_led_view got;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.func          <= it.func;
        item_bus.now_ms        <= it.now;
        item_bus.step_slot     <= it.slot;
        item_bus.step_color    <= it.color;
        item_bus.step_duration <= it.dur;
        item_bus.step_fade     <= it.fade;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        got = apply_item(it);
        pending_views.push_back(typed ? typed_view : got);
    endtask

    // Programs the step count. The sender stops and waits until every
    // predicted result has come, so the block is idle at the write.
    task automatic set_step_count(logic [COUNT_W-1:0] len);
        item_bus.valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= len;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        loop_len = len;
    endtask

    // Result side. Every result transaction is checked against the oldest
    // prediction. Ready idles at random, and on request it stays low for a
    // long stretch so that the block backs up and stalls its input.
    initial begin
        int        stall_left;
        t_led_view want;
        result_bus.ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
                if (pending_views.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual color %h step %0d",
                             $time, result_bus.color_out, result_bus.step_now);
                    errors++;
                end else begin
                    want = pending_views.pop_front();
                    if (result_bus.color_out !== want.color) begin
                        $display("%0t: color_out expected %h actual %h",
                                 $time, want.color, result_bus.color_out);
                        errors++;
                    end
                    if (result_bus.step_now !== want.step) begin
                        $display("%0t: step_now expected %0d actual %0d",
                                 $time, want.step, result_bus.step_now);
                        errors++;
                    end
                end
            end
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    // Sender: reset, directed table, random phases, then the drain and the
    // final verdict.
    initial begin
        t_led_row           rows [$];
        t_led_view          no_view;
        logic [COUNT_W-1:0] len;

        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_data               <= '0;
        item_bus.valid         <= 1'b0;
        item_bus.func          <= FUNC_TICK;
        item_bus.now_ms        <= '0;
        item_bus.step_slot     <= '0;
        item_bus.step_color    <= '0;
        item_bus.step_duration <= '0;
        item_bus.step_fade     <= 1'b0;

        errors       = 0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        no_view.color = '0;
        no_view.step  = '0;

        // State after reset. The table stays unknown until it is written.
        play_idx   = '0;
        step_t0    = '0;
        origin_rgb = '0;
        shown_rgb  = '0;
        loop_len   = COUNT_W'(1);

        // Every slot is loaded before the first tick, since a tick may read
        // any of them. These items leave the reset state showing black at
        // step zero.
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h0, 4'd0, 24'hFFFFFF, 16'd10, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h1, 4'd1, 24'h000000, 16'd0, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h2, 4'd2, 24'h123456, 16'hFFFF, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h3, 4'd3, 24'hFF00FF, 16'd4, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h4, 4'd4, 24'h00FF00, 16'd1, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h5, 4'd5, 24'h800001, 16'hFFFF, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h6, 4'd6, 24'h0F0F0F, 16'd7, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h7, 4'd7, 24'hF0F0F0, 16'd2, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h8, 4'd8, 24'h55AA55, 16'd20, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'h9, 4'd9, 24'hAA55AA, 16'd0, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hA, 4'd10, 24'h010203, 16'd3, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hB, 4'd11, 24'hFEFDFC, 16'd9, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hC, 4'd12, 24'h7F807F, 16'd100, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hD, 4'd13, 24'h808080, 16'd5, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hE, 4'd14, 24'h3C3C3C, 16'd16, 1, 1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_WRITE, 32'hF, 4'd15, 24'hC3C3C3, 16'd8, 1, 1, 0, 0));
        // The unused code and a restart change nothing that is shown.
        rows.push_back(make_row(0, 0, FUNC_UNUSED, 32'hFFFFFFFF, 4'd15, 24'hFFFFFF, 16'hFFFF, 1,
                                1, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_RESTART, 32'h0, 4'd0, 24'h0, 16'd0, 0, 1, 0, 0));
        // Halfway through the first fade, then past its end with a loop of one.
        rows.push_back(make_row(0, 0, FUNC_TICK, 32'd5, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_TICK, 32'd20, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        // Full table: advance into the zero-duration fade and straight out of it.
        rows.push_back(make_row(1, 16, FUNC_TICK, 32'd25, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_TICK, 32'd1000, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        rows.push_back(make_row(0, 0, FUNC_TICK, 32'd1000, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        // A count above the table size, and a restart just before the time wraps.
        rows.push_back(make_row(1, 31, FUNC_RESTART, 32'hFFFFFFF0, 4'd0, 24'h0, 16'd0, 0, 0, 0,
                                0));
        rows.push_back(make_row(0, 0, FUNC_TICK, 32'd10, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));
        // A step count of zero freezes the player.
        rows.push_back(make_row(1, 0, FUNC_TICK, 32'd77777, 4'd0, 24'h0, 16'd0, 0, 0, 0, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].set_len) set_step_count(rows[i].len);
            send_item(rows[i].item, gap_len(), rows[i].typed, rows[i].view);
        end

        wall_ms = 32'd77777;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: len = COUNT_W'(16);
                1: len = COUNT_W'(1);
                2: len = COUNT_W'(31);
                3: len = COUNT_W'(0);
                4: len = COUNT_W'(2);
                5: len = COUNT_W'(17);
                6: len = COUNT_W'(16);
                default: begin
                    if ($urandom_range(0, 7) == 0) len = COUNT_W'($urandom_range(0, 31));
                    else len = COUNT_W'($urandom_range(1, 16));
                end
            endcase
            set_step_count(len);
            calm = (phase == 4 || phase == 9);
            // The receiver holds off while the sender keeps offering items.
            if (phase == 1 || phase == 6) hold_off_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(), gap_len(), 1'b0, no_view);
                // Once, halfway through phase eight, the sender waits for every result to come.
                if (phase == 8 && n == PHASE_ITEMS / 2) begin
                    item_bus.valid <= 1'b0;
                    while (pending_views.size() != 0) @(posedge i_clk);
                end
            end
        end

        item_bus.valid <= 1'b0;
        while (pending_views.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("led_step_sequence_player: match");
        end else begin
            $display("led_step_sequence_player: mismatch");
        end
        $finish;
    end
endmodule
